/* hdl/elcc_pkg.sv */
// Shared types, codes and symbol tables for the escape-or-pack line codec.
// No dependencies; every other file in hdl imports this package.
package elcc_pkg;

  localparam int unsigned MaxResults = 5;

  // Values of the codec_mode register.
  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_PACK   = 2'd2;
  localparam logic [1:0] MODE_RESET  = MODE_PACK;

  // Direction of one item.
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // Line bytes with a special meaning.
  localparam logic [7:0] ESC_MARK     = 8'hDB;
  localparam logic [7:0] ESC_FOR_MARK = 8'hDC;
  localparam logic [7:0] ESC_FOR_ZERO = 8'hDD;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] SYM_PAIR0    = 8'hFF;
  localparam logic [7:0] SYM_PAIR1    = 8'hDF;
  localparam logic [7:0] SYM_PAIR2    = 8'hFB;
  localparam logic [7:0] SYM_PAIR3    = 8'hDB;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       line_start;
    logic       line_end;
  } item_t;

  typedef struct packed {
    logic       escape_pending;
    logic       header_seen;
    logic       line_halted;
    logic [1:0] symbol_count;
    logic [5:0] partial_value;
  } codec_state_t;

  // Up to five line or payload bytes, element 0 goes out first.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [2:0]                 count;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] pair;
  } sym_match_t;

  function automatic logic [7:0] pair_to_sym(input logic [1:0] pair);
    logic [7:0] sym;
    case (pair)
      2'd0:    sym = SYM_PAIR0;
      2'd1:    sym = SYM_PAIR1;
      2'd2:    sym = SYM_PAIR2;
      default: sym = SYM_PAIR3;
    endcase
    return sym;
  endfunction

  function automatic sym_match_t sym_to_pair(input logic [7:0] sym);
    sym_match_t m;
    m.valid = 1'b1;
    case (sym)
      SYM_PAIR0: m.pair = 2'd0;
      SYM_PAIR1: m.pair = 2'd1;
      SYM_PAIR2: m.pair = 2'd2;
      SYM_PAIR3: m.pair = 2'd3;
      default: begin
        m.valid = 1'b0;
        m.pair  = 2'd0;
      end
    endcase
    return m;
  endfunction

endpackage

/* hdl/elcc_codec.sv */
// Per-item encode and decode logic with the line decoder state registers.
// Depends on elcc_pkg.
module elcc_codec
  import elcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] mode,
  input  item_t      item,
  input  logic       take,
  output result_t    res
);

  codec_state_t state;
  codec_state_t state_next;
  codec_state_t cur;
  sym_match_t   match;

  always_comb begin
    res        = '0;
    cur        = item.line_start ? '0 : state;
    state_next = state;
    match      = sym_to_pair(item.data_byte);

    if (item.func == FUNC_ENCODE) begin
      case (mode)
        MODE_ESCAPE: begin
          if (item.data_byte == ESC_MARK) begin
            res.bytes[0] = ESC_MARK;
            res.bytes[1] = ESC_FOR_MARK;
            res.count    = 3'd2;
          end else if (item.data_byte == BYTE_ZERO) begin
            res.bytes[0] = ESC_MARK;
            res.bytes[1] = ESC_FOR_ZERO;
            res.count    = 3'd2;
          end else begin
            res.bytes[0] = item.data_byte;
            res.count    = 3'd1;
          end
        end
        MODE_PACK: begin
          if (item.line_start) begin
            res.bytes[0] = ESC_MARK;
            res.bytes[1] = pair_to_sym(item.data_byte[7:6]);
            res.bytes[2] = pair_to_sym(item.data_byte[5:4]);
            res.bytes[3] = pair_to_sym(item.data_byte[3:2]);
            res.bytes[4] = pair_to_sym(item.data_byte[1:0]);
            res.count    = 3'd5;
          end else begin
            res.bytes[0] = pair_to_sym(item.data_byte[7:6]);
            res.bytes[1] = pair_to_sym(item.data_byte[5:4]);
            res.bytes[2] = pair_to_sym(item.data_byte[3:2]);
            res.bytes[3] = pair_to_sym(item.data_byte[1:0]);
            res.count    = 3'd4;
          end
        end
        default: begin
          res.bytes[0] = item.data_byte;
          res.count    = 3'd1;
        end
      endcase
    end else begin
      state_next = cur;
      case (mode)
        MODE_ESCAPE: begin
          if (cur.escape_pending) begin
            state_next.escape_pending = 1'b0;
            res.count = 3'd1;
            if (item.data_byte == ESC_FOR_MARK) begin
              res.bytes[0] = ESC_MARK;
            end else if (item.data_byte == ESC_FOR_ZERO) begin
              res.bytes[0] = BYTE_ZERO;
            end else begin
              res.bytes[0] = item.data_byte;
            end
          end else if (item.data_byte == ESC_MARK && !item.line_end) begin
            state_next.escape_pending = 1'b1;
          end else begin
            res.bytes[0] = item.data_byte;
            res.count    = 3'd1;
          end
        end
        MODE_PACK: begin
          if (cur.line_halted) begin
            // Silent until the line ends.
          end else if (!cur.header_seen) begin
            if (item.data_byte == ESC_MARK) begin
              state_next.header_seen = 1'b1;
            end else begin
              state_next.line_halted = 1'b1;
            end
          end else if (!match.valid) begin
            state_next.line_halted   = 1'b1;
            state_next.symbol_count  = 2'd0;
            state_next.partial_value = 6'd0;
          end else if (cur.symbol_count == 2'd3) begin
            res.bytes[0] = {cur.partial_value, match.pair};
            res.count    = 3'd1;
            state_next.symbol_count  = 2'd0;
            state_next.partial_value = 6'd0;
          end else begin
            state_next.partial_value = {cur.partial_value[3:0], match.pair};
            state_next.symbol_count  = cur.symbol_count + 2'd1;
          end
        end
        default: begin
          res.bytes[0] = item.data_byte;
          res.count    = 3'd1;
        end
      endcase
      if (item.line_end) begin
        state_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      state <= state_next;
    end
  end

endmodule

/* hdl/elcc_burst.sv */
// Result buffer that holds the bytes of one item and sends them one per cycle while m_tready is high.
// Depends on elcc_pkg.
module elcc_burst
  import elcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    res,
  output logic       free,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  logic [MaxResults-1:0][7:0] bytes;
  logic [2:0]                 remaining;
  logic                       send;

  assign m_tvalid = (remaining != 3'd0);
  assign m_tdata  = bytes[0];
  assign m_tlast  = (remaining == 3'd1);
  assign send     = m_tvalid && m_tready;
  // The buffer can take a new set when empty or when its last byte leaves now.
  assign free     = (remaining == 3'd0) || (m_tlast && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 3'd0;
    end else if (load) begin
      remaining <= res.count;
    end else if (send) begin
      remaining <= remaining - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= res.bytes;
    end else if (send) begin
      bytes <= {8'h00, bytes[MaxResults-1:1]};
    end
  end

endmodule

/* hdl/escape_or_pack4_line_codec_top.sv */
// Top level of the escape-or-pack line codec: input register, codec logic,
// result buffer and the mode register. Depends on elcc_pkg, elcc_codec, elcc_burst.
//
//   Channel   Direction  Signals                         Carries
//   s_axis    in         s_tvalid s_tready s_tdata       one byte to encode or decode
//                        s_tuser s_tlast
//   m_axis    out        m_tvalid m_tready m_tdata       one line or payload byte
//                        m_tlast
//   cfg       in         cfg_wr_en cfg_wr_data           codec_mode register
//
// An accepted item is held in the input register, where the codec logic works
// out all of its result bytes; they are loaded into the result buffer once it
// is free and leave one per cycle while m_tready is high.
// An item sends one output byte per result, up to five (five for a packed first
// byte of a line); an item without results loads nothing into the buffer.
// Reset is synchronous and active high; it clears the decoder state, empties both
// registers and sets the mode to packing. A stall on m_tready holds the buffer and,
// once the input register is waiting as well, lowers s_tready.
module escape_or_pack4_line_codec_top
  import elcc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // Input stream.
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic [1:0] s_tuser,   // [0] func, [1] line_start
  input  logic       s_tlast,   // line_end
  // Output stream.
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,   // last result of the item
  // Mode register write port.
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  logic [1:0] mode;
  logic       in_valid;
  item_t      in_item;
  result_t    res;
  logic       burst_free;
  logic       advance;

  // The held item moves on once its results, if any, have room in the buffer.
  assign advance  = in_valid && ((res.count == 3'd0) || burst_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (cfg_wr_en) begin
      mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Payload register: only loaded on a transfer, so it needs no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.func       <= s_tuser[0];
      in_item.data_byte  <= s_tdata;
      in_item.line_start <= s_tuser[1];
      in_item.line_end   <= s_tlast;
    end
  end

  elcc_codec u_codec (
    .clk  (clk),
    .rst  (rst),
    .mode (mode),
    .item (in_item),
    .take (advance),
    .res  (res)
  );

  elcc_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && (res.count != 3'd0)),
    .res      (res),
    .free     (burst_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
